@@ rtl/windowed_stats_threshold_alarm_top_macros.svh @@
// Assertion macros for the windowed stats threshold alarm block.
// Used by the top level; no other dependencies.
`ifndef WINDOWED_STATS_THRESHOLD_ALARM_TOP_MACROS_SVH
`define WINDOWED_STATS_THRESHOLD_ALARM_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define WSTA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WSTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WSTA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define WSTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/wsta_pkg.sv @@
// Shared constants, types and codes for the windowed stats threshold alarm.
// No dependencies.
package wsta_pkg;

    localparam int MAX_WINDOW_SAMPLES = 2048;
    localparam int CNT_W      = $clog2(MAX_WINDOW_SAMPLES + 1);
    localparam int SUM_W      = 16 + $clog2(MAX_WINDOW_SAMPLES);
    localparam int NUM_W      = SUM_W + 4;
    localparam int DIV_STEP_W = $clog2(NUM_W + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUNNING_SPEED_LIMIT    = 2'd0,
        CFG_FUEL_LOW_THRESHOLD     = 2'd1,
        CFG_COOLANT_HIGH_THRESHOLD = 2'd2,
        CFG_OIL_LOW_THRESHOLD      = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] RST_SPEED_LIMIT = 16'd500;
    localparam logic [10:0] RST_FUEL_THR    = 11'd320;
    localparam logic [11:0] RST_COOL_THR    = 12'd1520;
    localparam logic [14:0] RST_OIL_THR     = 15'd1600;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;

    typedef struct packed {
        logic [15:0] speed_limit;
        logic [10:0] fuel_thr;
        logic [11:0] cool_thr;
        logic [14:0] oil_thr;
    } cfg_t;

    typedef struct packed {
        logic sample_upd;
        logic div_start;
        logic div_sel_oil;
        logic cap_fuel;
        logic cap_oil;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic total_zero;
        logic running_zero;
        logic div_done;
        logic div_busy;
        logic out_busy;
    } status_t;

    typedef struct packed {
        logic               fuel_low_alert;
        logic               coolant_high_alert;
        logic               oil_low_alert;
        logic [19:0]        fuel_mean_q4;
        logic [19:0]        oil_mean_q4;
        logic               oil_mean_valid;
        logic signed [15:0] coolant_peak_out;
        logic [15:0]        load_peak_out;
        logic [15:0]        oil_peak_out;
        logic [11:0]        running_count_out;
        logic [11:0]        stopped_count_out;
        logic [15:0]        last_hours_out;
    } result_t;

endpackage

@@ rtl/wsta_ifs.sv @@
// Handshake channel interfaces: sample items in, result items out, config writes.
// Depends on wsta_pkg.
interface wsta_sample_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [15:0]        engine_speed;
    logic [15:0]        fuel_level;
    logic [15:0]        load_level;
    logic [15:0]        oil_pressure;
    logic signed [15:0] coolant_temp;
    logic [15:0]        hour_meter;

    modport source (output valid, kind, engine_speed, fuel_level, load_level,
                    oil_pressure, coolant_temp, hour_meter, input ready);
    modport sink (input valid, kind, engine_speed, fuel_level, load_level,
                  oil_pressure, coolant_temp, hour_meter, output ready);
endinterface

interface wsta_report_if;
    logic               valid;
    logic               ready;
    logic               fuel_low_alert;
    logic               coolant_high_alert;
    logic               oil_low_alert;
    logic [19:0]        fuel_mean_q4;
    logic [19:0]        oil_mean_q4;
    logic               oil_mean_valid;
    logic signed [15:0] coolant_peak_out;
    logic [15:0]        load_peak_out;
    logic [15:0]        oil_peak_out;
    logic [11:0]        running_count_out;
    logic [11:0]        stopped_count_out;
    logic [15:0]        last_hours_out;

    modport source (output valid, fuel_low_alert, coolant_high_alert, oil_low_alert,
                    fuel_mean_q4, oil_mean_q4, oil_mean_valid, coolant_peak_out,
                    load_peak_out, oil_peak_out, running_count_out,
                    stopped_count_out, last_hours_out, input ready);
    modport sink (input valid, fuel_low_alert, coolant_high_alert, oil_low_alert,
                  fuel_mean_q4, oil_mean_q4, oil_mean_valid, coolant_peak_out,
                  load_peak_out, oil_peak_out, running_count_out,
                  stopped_count_out, last_hours_out, output ready);
endinterface

interface wsta_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [wsta_pkg::CFG_IDX_W-1:0]   index;
    logic [wsta_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/wsta_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wsta_pkg.
module wsta_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wsta_pkg::NUM_W-1:0]  dividend,
    input  logic [wsta_pkg::CNT_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [wsta_pkg::NUM_W-1:0]  quotient
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [wsta_pkg::DIV_STEP_W-1:0]  step_reg;
    logic [wsta_pkg::CNT_W-1:0]       rem_reg;
    logic [wsta_pkg::NUM_W-1:0]       quo_reg;
    logic [wsta_pkg::CNT_W-1:0]       dsr_reg;

    logic [wsta_pkg::CNT_W:0]         shifted;
    logic [wsta_pkg::CNT_W:0]         diff;
    logic                             ge;

    assign shifted = {rem_reg, quo_reg[wsta_pkg::NUM_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            // done pulses for one cycle after the last step
            done_reg <= !start && busy_reg && (step_reg == wsta_pkg::DIV_STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= wsta_pkg::DIV_STEP_W'(wsta_pkg::NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == wsta_pkg::DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // operands and partial remainder carry no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[wsta_pkg::CNT_W-1:0] : shifted[wsta_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[wsta_pkg::NUM_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/wsta_ctrl.sv @@
// Controller: accepts items and sequences the two divisions and the result load.
// Depends on wsta_pkg.
module wsta_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    input  wsta_pkg::status_t st,
    output logic              in_ready,
    output wsta_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_FUEL,
        S_DIV_OIL,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   start_reg;
    logic   start_next;
    logic   sel_oil_reg;
    logic   accept;

    assign accept = in_valid && ready_reg;

    always_comb
    begin
        cmd.sample_upd  = accept && (in_kind == wsta_pkg::KIND_SAMPLE);
        cmd.div_start   = start_reg;
        cmd.div_sel_oil = sel_oil_reg;
        cmd.cap_fuel    = (state_reg == S_DIV_FUEL) && st.div_done;
        cmd.cap_oil     = (state_reg == S_DIV_OIL) && st.div_done;
        cmd.finish      = (state_reg == S_FINISH) && !st.out_busy;
    end

    // divider kick: on a non-empty close, and again for the oil mean
    always_comb
    begin
        start_next = ((state_reg == S_IDLE) && accept && (in_kind == wsta_pkg::KIND_CLOSE)
                      && !st.total_zero)
                  || ((state_reg == S_DIV_FUEL) && st.div_done && !st.running_zero);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ready_reg   <= 1'b1;
            start_reg   <= 1'b0;
            sel_oil_reg <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    // an empty window close is taken and dropped
                    if (accept && (in_kind == wsta_pkg::KIND_CLOSE) && !st.total_zero)
                    begin
                        state_reg   <= S_DIV_FUEL;
                        ready_reg   <= 1'b0;
                        sel_oil_reg <= 1'b0;
                    end
                end
                S_DIV_FUEL:
                begin
                    if (st.div_done)
                    begin
                        if (st.running_zero)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg   <= S_DIV_OIL;
                            sel_oil_reg <= 1'b1;
                        end
                    end
                end
                S_DIV_OIL:
                begin
                    if (st.div_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!st.out_busy)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
            endcase
        end
    end

    assign in_ready = ready_reg;

endmodule

@@ rtl/wsta_dp.sv @@
// Datapath: window accumulators, shared divider, alert latches, result register.
// Depends on wsta_pkg and wsta_div.
module wsta_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  wsta_pkg::cmd_t     cmd,
    input  wsta_pkg::cfg_t     cfg,
    input  logic [15:0]        engine_speed,
    input  logic [15:0]        fuel_level,
    input  logic [15:0]        load_level,
    input  logic [15:0]        oil_pressure,
    input  logic signed [15:0] coolant_temp,
    input  logic [15:0]        hour_meter,
    input  logic               res_ready,
    output wsta_pkg::status_t  st,
    output wsta_pkg::result_t  res,
    output logic               res_valid
);

    logic [wsta_pkg::CNT_W-1:0]  running_reg;
    logic [wsta_pkg::CNT_W-1:0]  stopped_reg;
    logic [wsta_pkg::SUM_W-1:0]  fuel_total_reg;
    logic [wsta_pkg::SUM_W-1:0]  oil_total_reg;
    logic [15:0]                 load_max_reg;
    logic [15:0]                 oil_max_reg;
    logic signed [15:0]          cool_max_reg;
    logic [15:0]                 last_hours_reg;
    logic                        fuel_latch_reg;
    logic                        cool_latch_reg;
    logic                        oil_latch_reg;
    logic                        res_valid_reg;
    wsta_pkg::result_t           res_reg;
    logic [wsta_pkg::NUM_W-1:0]  fuel_q_reg;
    logic [wsta_pkg::NUM_W-1:0]  oil_q_reg;

    logic [wsta_pkg::CNT_W-1:0]  total;
    logic                        full;
    logic                        is_running;
    logic [wsta_pkg::NUM_W-1:0]  div_dividend;
    logic [wsta_pkg::CNT_W-1:0]  div_divisor;
    logic [wsta_pkg::NUM_W-1:0]  div_quotient;
    logic                        div_busy;
    logic                        div_done;
    logic                        oil_valid;
    logic                        fuel_cond;
    logic                        cool_cond;
    logic                        oil_cond;
    logic signed [19:0]          cool_scaled;
    logic signed [19:0]          cool_thr_s;

    assign total      = wsta_pkg::CNT_W'(running_reg + stopped_reg);
    assign full       = total >= wsta_pkg::CNT_W'(wsta_pkg::MAX_WINDOW_SAMPLES);
    assign is_running = engine_speed >= cfg.speed_limit;

    assign div_dividend = cmd.div_sel_oil ? {oil_total_reg, 4'b0000}
                                          : {fuel_total_reg, 4'b0000};
    assign div_divisor  = cmd.div_sel_oil ? running_reg : total;

    wsta_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // alert conditions, evaluated on the captured means and peak
    assign oil_valid   = running_reg != '0;
    assign fuel_cond   = fuel_q_reg < wsta_pkg::NUM_W'(cfg.fuel_thr);
    assign cool_scaled = {cool_max_reg, 4'b0000};
    assign cool_thr_s  = $signed({8'b0, cfg.cool_thr});
    assign cool_cond   = cool_scaled > cool_thr_s;
    assign oil_cond    = oil_valid && (oil_q_reg < wsta_pkg::NUM_W'(cfg.oil_thr));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= '0;
            stopped_reg    <= '0;
            fuel_total_reg <= '0;
            oil_total_reg  <= '0;
            load_max_reg   <= '0;
            oil_max_reg    <= '0;
            cool_max_reg   <= '0;
            last_hours_reg <= '0;
            fuel_latch_reg <= 1'b0;
            cool_latch_reg <= 1'b0;
            oil_latch_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready && !cmd.finish)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cmd.finish)
            begin
                fuel_latch_reg <= fuel_cond;
                cool_latch_reg <= cool_cond;
                oil_latch_reg  <= oil_cond;
                res_valid_reg  <= 1'b1;
                running_reg    <= '0;
                stopped_reg    <= '0;
                fuel_total_reg <= '0;
                oil_total_reg  <= '0;
                load_max_reg   <= '0;
                oil_max_reg    <= '0;
                cool_max_reg   <= '0;
                last_hours_reg <= '0;
            end
            else if (cmd.sample_upd && !full)
            begin
                if (is_running)
                begin
                    running_reg   <= running_reg + 1'b1;
                    oil_total_reg <= oil_total_reg + wsta_pkg::SUM_W'(oil_pressure);
                    if (load_level > load_max_reg)
                    begin
                        load_max_reg <= load_level;
                    end
                    if (oil_pressure > oil_max_reg)
                    begin
                        oil_max_reg <= oil_pressure;
                    end
                end
                else
                begin
                    stopped_reg <= stopped_reg + 1'b1;
                end
                fuel_total_reg <= fuel_total_reg + wsta_pkg::SUM_W'(fuel_level);
                if (coolant_temp > cool_max_reg)
                begin
                    cool_max_reg <= coolant_temp;
                end
                last_hours_reg <= hour_meter;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_fuel)
        begin
            fuel_q_reg <= div_quotient;
        end
        if (cmd.cap_oil)
        begin
            oil_q_reg <= div_quotient;
        end
        if (cmd.finish)
        begin
            res_reg.fuel_low_alert     <= fuel_cond && !fuel_latch_reg;
            res_reg.coolant_high_alert <= cool_cond && !cool_latch_reg;
            res_reg.oil_low_alert      <= oil_cond && !oil_latch_reg;
            res_reg.fuel_mean_q4       <= 20'(fuel_q_reg);
            res_reg.oil_mean_q4        <= oil_valid ? 20'(oil_q_reg) : 20'd0;
            res_reg.oil_mean_valid     <= oil_valid;
            res_reg.coolant_peak_out   <= cool_max_reg;
            res_reg.load_peak_out      <= load_max_reg;
            res_reg.oil_peak_out       <= oil_max_reg;
            res_reg.running_count_out  <= 12'(running_reg);
            res_reg.stopped_count_out  <= 12'(stopped_reg);
            res_reg.last_hours_out     <= last_hours_reg;
        end
    end

    always_comb
    begin
        st.total_zero   = total == '0;
        st.running_zero = !oil_valid;
        st.div_done     = div_done;
        st.div_busy     = div_busy;
        st.out_busy     = res_valid_reg && !res_ready;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

@@ rtl/windowed_stats_threshold_alarm_top.sv @@
// Top level of the windowed stats threshold alarm: config registers, controller,
// datapath. Depends on wsta_pkg, the channel interfaces, wsta_ctrl, wsta_dp.
//
// Sample items (kind 0) are taken one per cycle while no close is being
// processed, and are folded into the window statistics in the cycle they are
// accepted; samples past the window bound are dropped. A close item (kind 1)
// on a non-empty window runs the fuel mean and, if any running samples came,
// the oil mean through one shared bit-serial divider of NUM_W (31) steps. A
// close therefore holds the sample channel until the divisions are done and
// the result is loaded, including any time spent waiting for a previous
// result to be taken. The result sits in an output register, so samples keep
// flowing while it waits. An empty close is accepted and produces nothing.
// Config writes are always accepted and must only happen while the block is
// idle.
`include "windowed_stats_threshold_alarm_top_macros.svh"

module windowed_stats_threshold_alarm_top (
    input  logic           clk,
    input  logic           rst_n,
    wsta_sample_if.sink    sample,
    wsta_report_if.source  report,
    wsta_cfg_if.sink       cfg
);

    wsta_pkg::cfg_t     cfg_reg;
    wsta_pkg::cmd_t     cmd;
    wsta_pkg::status_t  st;
    wsta_pkg::result_t  res;
    logic               res_valid;
    logic               in_ready;

    // config register file, write-only, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_limit <= wsta_pkg::RST_SPEED_LIMIT;
            cfg_reg.fuel_thr    <= wsta_pkg::RST_FUEL_THR;
            cfg_reg.cool_thr    <= wsta_pkg::RST_COOL_THR;
            cfg_reg.oil_thr     <= wsta_pkg::RST_OIL_THR;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (wsta_pkg::cfg_idx_t'(cfg.index))
                wsta_pkg::CFG_RUNNING_SPEED_LIMIT:    cfg_reg.speed_limit <= cfg.data;
                wsta_pkg::CFG_FUEL_LOW_THRESHOLD:     cfg_reg.fuel_thr    <= cfg.data[10:0];
                wsta_pkg::CFG_COOLANT_HIGH_THRESHOLD: cfg_reg.cool_thr    <= cfg.data[11:0];
                wsta_pkg::CFG_OIL_LOW_THRESHOLD:      cfg_reg.oil_thr     <= cfg.data[14:0];
            endcase
        end
    end

    // sequencing: accept, divide fuel, divide oil, load result
    wsta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_kind  (sample.kind),
        .st       (st),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    assign sample.ready = in_ready;

    // accumulators, divider, latches and the result register
    wsta_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg_reg),
        .engine_speed (sample.engine_speed),
        .fuel_level   (sample.fuel_level),
        .load_level   (sample.load_level),
        .oil_pressure (sample.oil_pressure),
        .coolant_temp (sample.coolant_temp),
        .hour_meter   (sample.hour_meter),
        .res_ready    (report.ready),
        .st           (st),
        .res          (res),
        .res_valid    (res_valid)
    );

    assign report.valid              = res_valid;
    assign report.fuel_low_alert     = res.fuel_low_alert;
    assign report.coolant_high_alert = res.coolant_high_alert;
    assign report.oil_low_alert      = res.oil_low_alert;
    assign report.fuel_mean_q4       = res.fuel_mean_q4;
    assign report.oil_mean_q4        = res.oil_mean_q4;
    assign report.oil_mean_valid     = res.oil_mean_valid;
    assign report.coolant_peak_out   = res.coolant_peak_out;
    assign report.load_peak_out      = res.load_peak_out;
    assign report.oil_peak_out       = res.oil_peak_out;
    assign report.running_count_out  = res.running_count_out;
    assign report.stopped_count_out  = res.stopped_count_out;
    assign report.last_hours_out     = res.last_hours_out;

    // no item is taken while the divider runs
    `WSTA_ASSERT_IMPL(a_no_accept_in_div, clk, rst_n, st.div_busy, !sample.ready, "item accepted during division")
    // a new result never overwrites one still waiting
    `WSTA_ASSERT_IMPL(a_no_clobber, clk, rst_n, cmd.finish, !report.valid || report.ready, "result overwritten")
    // the window is empty right after a result is loaded
    `WSTA_ASSERT_NEXT(a_window_cleared, clk, rst_n, cmd.finish, st.total_zero, "window not cleared")
    // a division only starts on a non-empty window
    `WSTA_ASSERT_IMPL(a_start_nonempty, clk, rst_n, cmd.div_start, !st.total_zero, "division on empty window")

endmodule
